// ===== rtl/lbwg_pkg.sv =====
// Shared constants, register and result codes, and the arctangent table of the wall mapper.
package lbwg_pkg;

	localparam int GRID_CELLS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int STORE_DEPTH  = (GRID_CELLS + 1) * GRID_CELLS;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);

	localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
	localparam logic [16:0] NO_RANGE     = 17'd100000;

	// dividing unit: integer mm by the half-cell pitch
	localparam int DIV_W     = 20;
	localparam int DIVISOR   = 500;
	localparam int REM_W     = 9;
	// ceil(2^24 / 125), exact for quarters below 2^18
	localparam int DIV_MUL   = 134218;
	localparam int DIV_SHIFT = 24;

	localparam logic [2:0] REG_X     = 3'd0;
	localparam logic [2:0] REG_Y     = 3'd1;
	localparam logic [2:0] REG_HEAD  = 3'd2;
	localparam logic [2:0] REG_STEP  = 3'd3;
	localparam logic [2:0] REG_FIRST = 3'd4;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_XWALL = 2'd1;
	localparam logic [1:0] KIND_YWALL = 2'd2;
	localparam logic [1:0] KIND_OUT   = 2'd3;

	// arctan(2^-i) in 2^-24 turn
	function automatic logic [22:0] atan_turn24(input logic [4:0] i);
		logic [22:0] v;
		case (i)
			5'd0:  v = 23'd2097152;
			5'd1:  v = 23'd1238021;
			5'd2:  v = 23'd654136;
			5'd3:  v = 23'd332050;
			5'd4:  v = 23'd166669;
			5'd5:  v = 23'd83416;
			5'd6:  v = 23'd41718;
			5'd7:  v = 23'd20860;
			5'd8:  v = 23'd10430;
			5'd9:  v = 23'd5215;
			5'd10: v = 23'd2608;
			5'd11: v = 23'd1304;
			5'd12: v = 23'd652;
			5'd13: v = 23'd326;
			5'd14: v = 23'd163;
			5'd15: v = 23'd81;
			5'd16: v = 23'd41;
			5'd17: v = 23'd20;
			5'd18: v = 23'd10;
			5'd19: v = 23'd5;
			5'd20: v = 23'd3;
			5'd21: v = 23'd1;
			5'd22: v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/lbwg_div.sv =====
// Division by the half-cell pitch: quotient and remainder by reciprocal multiplication.
module lbwg_div (
	input  logic [lbwg_pkg::DIV_W-1:0]   dividend,
	output logic [lbwg_pkg::DIV_W-1:0]   quot,
	output logic [lbwg_pkg::REM_W-1:0]   rem
);

	localparam int QTR_W  = lbwg_pkg::DIV_W - 2;
	localparam int PROD_W = QTR_W + 18;

	logic [QTR_W-1:0]             quarter;
	logic [PROD_W-1:0]            prod;
	logic [lbwg_pkg::DIV_W-1:0]   back;

	// n / 500 = (n / 4) / 125, the second by multiplying with the reciprocal
	assign quarter = dividend[lbwg_pkg::DIV_W-1:2];
	assign prod    = PROD_W'(quarter) * PROD_W'(lbwg_pkg::DIV_MUL);
	assign quot    = lbwg_pkg::DIV_W'(prod[PROD_W-1:lbwg_pkg::DIV_SHIFT]);
	assign back    = lbwg_pkg::DIV_W'(32'(quot) * lbwg_pkg::DIVISOR);
	assign rem     = lbwg_pkg::REM_W'(dividend - back);

endmodule

// ===== rtl/lidar_beam_wall_grid_mapper.sv =====
// Lidar beam to wall-grid mapper: sequencer, CORDIC rotation, wall stores and APB registers.
//
// Input words arrive on s_*: s_tuser is the action (0 beam, 1 wall read), s_tlast marks the
// last beam of a scan. Results leave on m_*, one word per input word: m_tuser is wall_kind,
// m_tlast is scan_done. Robot pose and beam geometry are set over the APB port; the user
// must set them only while idle, and the block itself does not enforce it.
// A beam runs through one shared datapath under a small sequencer: the products, the
// quarter-turn pre-rotation, CORDIC_STEPS steps of the shift-add CORDIC, adding the pose,
// a sign check, then the divider by 500 (reciprocal multiply) runs twice, x then y, and
// the wall store is marked and the result handed off. A beam with no return goes from the
// products straight to the hand-off, one with a negative coordinate from the sign check;
// a wall read reads the stores and then hands off its result.
// s_tready is high only in idle; one word is in flight at a time. The result sits in an
// output register, so a new word is taken while a result still waits on m_tready; the
// sequencer holds its finished result until that register is free.
// After reset both wall stores (272 entries each) are cleared one entry per cycle, while
// s_tready stays low; registers are writable throughout.
module lidar_beam_wall_grid_mapper (
	input  logic        clk,
	input  logic        arst_n,
	// APB
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	// beam_index[11:0], range_mm[28:12], range_infinite[29], read_kind[30],
	// read_row[35:31], read_col[40:36], zero fill
	input  logic [47:0] s_tdata,
	input  logic        s_tuser,    // action
	input  logic        s_tlast,    // last_beam
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_row[4:0], cell_col[9:5], read_bit[10], nearest_range_mm[27:11],
	// nearest_angle[43:28], zero fill
	output logic [47:0] m_tdata,
	output logic [1:0]  m_tuser,    // wall_kind
	output logic        m_tlast     // scan_done
);

	localparam int AW = lbwg_pkg::ADDR_W;
	localparam int GC = lbwg_pkg::GRID_CELLS;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_PREP = 4'd2;
	localparam logic [3:0] S_ROT  = 4'd3;
	localparam logic [3:0] S_CORD = 4'd4;
	localparam logic [3:0] S_POS  = 4'd5;
	localparam logic [3:0] S_CHK  = 4'd6;
	localparam logic [3:0] S_DIVX = 4'd7;
	localparam logic [3:0] S_DIVY = 4'd8;
	localparam logic [3:0] S_MARK = 4'd9;
	localparam logic [3:0] S_RD   = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	localparam logic signed [25:0] QUARTER = 26'sd4194304;

	// configuration
	logic [17:0] rx_q, ry_q;
	logic [15:0] hd_q, first_q;
	logic [23:0] step_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q    <= '0;
			ry_q    <= '0;
			hd_q    <= '0;
			step_q  <= '0;
			first_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				lbwg_pkg::REG_X:     rx_q    <= pwdata[17:0];
				lbwg_pkg::REG_Y:     ry_q    <= pwdata[17:0];
				lbwg_pkg::REG_HEAD:  hd_q    <= pwdata[15:0];
				lbwg_pkg::REG_STEP:  step_q  <= pwdata[23:0];
				lbwg_pkg::REG_FIRST: first_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			lbwg_pkg::REG_X:     prdata = {14'd0, rx_q};
			lbwg_pkg::REG_Y:     prdata = {14'd0, ry_q};
			lbwg_pkg::REG_HEAD:  prdata = {16'd0, hd_q};
			lbwg_pkg::REG_STEP:  prdata = {8'd0, step_q};
			lbwg_pkg::REG_FIRST: prdata = {16'd0, first_q};
			default:             prdata = '0;
		endcase
	end

	// sequencer and datapath state
	logic [3:0]  state_q;
	logic [AW-1:0] clr_q;
	logic        scan_open_q;
	logic [16:0] near_rng_q;
	logic [15:0] near_ang_q;
	logic        out_valid_q;

	logic        act_q, inf_q, last_q, rkind_q;
	logic [11:0] idx_q;
	logic [16:0] rng_q;
	logic [4:0]  rrow_q, rcol_q;

	logic [23:0] sweep_q;
	logic signed [39:0] x_q, y_q;
	logic signed [25:0] ang_q;
	logic [4:0]  it_q;
	logic [1:0]  kind_q;
	logic [4:0]  row_q, col_q;
	logic [lbwg_pkg::DIV_W-1:0] qx_q, qy_q;
	logic [lbwg_pkg::REM_W-1:0] remx_q, remy_q;

	logic [1:0]  o_kind_q;
	logic [4:0]  o_row_q, o_col_q;
	logic        o_rbit_q, o_done_q;
	logic [16:0] o_rng_q;
	logic [15:0] o_ang_q;

	logic        accept;
	logic        out_free;
	assign accept   = s_tvalid & s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;

	// products
	logic [32:0] prod;
	logic [35:0] sweep_full;
	assign prod       = 33'(rng_q) * 33'(lbwg_pkg::INV_GAIN_Q16);
	assign sweep_full = 36'(step_q) * 36'(idx_q);

	// angle and nearest angle
	logic [23:0]        a24;
	logic signed [25:0] a_s;
	logic [24:0]        na_sum;
	assign a24    = sweep_q + {hd_q, 8'd0};
	assign a_s    = {{2{a24[23]}}, a24};
	assign na_sum = {1'b0, ({first_q, 8'd0} + sweep_q)} + 25'd128;

	// CORDIC step
	logic signed [39:0] dx, dy;
	logic signed [25:0] at_s;
	assign dx   = y_q >>> it_q;
	assign dy   = x_q >>> it_q;
	assign at_s = {3'd0, lbwg_pkg::atan_turn24(it_q)};

	// divider, shared by x and y; integer mm of a nonnegative point fits in DIV_W bits
	logic [lbwg_pkg::DIV_W-1:0]   div_in, div_q;
	logic [lbwg_pkg::REM_W-1:0]   div_r;
	logic                         nonneg;

	assign nonneg = !x_q[39] && !y_q[39];
	assign div_in = (state_q == S_DIVX) ? x_q[35:16] : y_q[35:16];

	lbwg_div u_div (
		.dividend (div_in),
		.quot     (div_q),
		.rem      (div_r)
	);

	// wall decision: index = floor((mm + 250) / 500)
	logic        keep;
	logic [lbwg_pkg::DIV_W:0]   xi, yi;
	logic [lbwg_pkg::DIV_W-1:0] wr, wc;
	logic        mark_x, mark_y, in_x, in_y;
	logic [AW-1:0] wa_x, wa_y;

	assign keep = (remx_q < lbwg_pkg::REM_W'(150)) || (remx_q > lbwg_pkg::REM_W'(350)) ||
		((remx_q == lbwg_pkg::REM_W'(350)) && (x_q[15:0] != 16'd0));
	assign xi = {1'b0, qx_q} + (lbwg_pkg::DIV_W+1)'(remx_q >= lbwg_pkg::REM_W'(250));
	assign yi = {1'b0, qy_q} + (lbwg_pkg::DIV_W+1)'(remy_q >= lbwg_pkg::REM_W'(250));
	assign wr = xi[lbwg_pkg::DIV_W:1];
	assign wc = yi[lbwg_pkg::DIV_W:1];
	assign in_x = (wr < lbwg_pkg::DIV_W'(GC + 1)) && (wc < lbwg_pkg::DIV_W'(GC));
	assign in_y = (wr < lbwg_pkg::DIV_W'(GC)) && (wc < lbwg_pkg::DIV_W'(GC + 1));
	assign wa_x = AW'(32'(wr[AW-1:0]) * GC + 32'(wc[AW-1:0]));
	assign wa_y = AW'(32'(wr[AW-1:0]) * (GC + 1) + 32'(wc[AW-1:0]));
	assign mark_x = (state_q == S_MARK) && keep && !xi[0] && yi[0] && in_x;
	assign mark_y = (state_q == S_MARK) && keep && xi[0] && !yi[0] && in_y;

	// wall stores
	logic          mem_x [lbwg_pkg::STORE_DEPTH];
	logic          mem_y [lbwg_pkg::STORE_DEPTH];
	logic          clearing;
	logic          rdx_q, rdy_q;
	logic [AW-1:0] ra_x, ra_y;
	logic          rd_in;
	logic          rbit;

	assign clearing = (state_q == S_CLR);
	assign ra_x  = AW'(32'(rrow_q) * GC + 32'(rcol_q));
	assign ra_y  = AW'(32'(rrow_q) * (GC + 1) + 32'(rcol_q));
	assign rd_in = rkind_q ? ((32'(rrow_q) < GC) && (32'(rcol_q) < GC + 1))
	                       : ((32'(rrow_q) < GC + 1) && (32'(rcol_q) < GC));
	assign rbit  = rd_in && (rkind_q ? rdy_q : rdx_q);

	always_ff @(posedge clk) begin
		if (clearing || mark_x) begin
			mem_x[clearing ? clr_q : wa_x] <= !clearing;
		end
		if (clearing || mark_y) begin
			mem_y[clearing ? clr_q : wa_y] <= !clearing;
		end
		rdx_q <= mem_x[ra_x];
		rdy_q <= mem_y[ra_y];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			scan_open_q <= 1'b0;
			near_rng_q  <= lbwg_pkg::NO_RANGE;
			near_ang_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(lbwg_pkg::STORE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= s_tuser ? S_RD : S_PREP;
					end
				end
				S_PREP: begin
					scan_open_q <= 1'b1;
					if (!scan_open_q) begin
						near_rng_q <= lbwg_pkg::NO_RANGE;
						near_ang_q <= '0;
					end
					state_q <= inf_q ? S_FIN : S_ROT;
				end
				S_ROT: begin
					if (rng_q < near_rng_q) begin
						near_rng_q <= rng_q;
						near_ang_q <= na_sum[23:8];
					end
					state_q <= S_CORD;
				end
				S_CORD: begin
					if (it_q == 5'(lbwg_pkg::CORDIC_STEPS - 1)) begin
						state_q <= S_POS;
					end
				end
				S_POS:  state_q <= S_CHK;
				S_CHK:  state_q <= nonneg ? S_DIVX : S_FIN;
				S_DIVX: state_q <= S_DIVY;
				S_DIVY: state_q <= S_MARK;
				S_MARK: state_q <= S_FIN;
				S_RD:   state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						if (!act_q && last_q) begin
							scan_open_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q   <= s_tuser;
				last_q  <= s_tlast;
				idx_q   <= s_tdata[11:0];
				rng_q   <= s_tdata[28:12];
				inf_q   <= s_tdata[29];
				rkind_q <= s_tdata[30];
				rrow_q  <= s_tdata[35:31];
				rcol_q  <= s_tdata[40:36];
				kind_q  <= lbwg_pkg::KIND_NONE;
				row_q   <= '0;
				col_q   <= '0;
			end
			S_PREP: begin
				sweep_q <= sweep_full[23:0];
				x_q     <= {7'd0, prod};
			end
			S_ROT: begin
				it_q <= '0;
				if (a_s > QUARTER) begin
					y_q   <= x_q;
					x_q   <= '0;
					ang_q <= a_s - QUARTER;
				end else if (a_s < -QUARTER) begin
					y_q   <= -x_q;
					x_q   <= '0;
					ang_q <= a_s + QUARTER;
				end else begin
					y_q   <= '0;
					ang_q <= a_s;
				end
			end
			S_CORD: begin
				it_q <= it_q + 1'b1;
				if (!ang_q[25]) begin
					x_q   <= x_q - dx;
					y_q   <= y_q + dy;
					ang_q <= ang_q - at_s;
				end else begin
					x_q   <= x_q + dx;
					y_q   <= y_q - dy;
					ang_q <= ang_q + at_s;
				end
			end
			S_POS: begin
				x_q <= x_q + {{6{rx_q[17]}}, rx_q, 16'd0};
				y_q <= y_q + {{6{ry_q[17]}}, ry_q, 16'd0};
			end
			S_DIVX: begin
				qx_q   <= div_q;
				remx_q <= div_r;
			end
			S_DIVY: begin
				qy_q   <= div_q;
				remy_q <= div_r;
			end
			S_MARK: begin
				if (keep && (xi[0] != yi[0])) begin
					if (mark_x) begin
						kind_q <= lbwg_pkg::KIND_XWALL;
					end else if (mark_y) begin
						kind_q <= lbwg_pkg::KIND_YWALL;
					end else begin
						kind_q <= lbwg_pkg::KIND_OUT;
					end
					if (mark_x || mark_y) begin
						row_q <= wr[4:0];
						col_q <= wc[4:0];
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					o_kind_q <= act_q ? lbwg_pkg::KIND_NONE : kind_q;
					o_row_q  <= act_q ? 5'd0 : row_q;
					o_col_q  <= act_q ? 5'd0 : col_q;
					o_rbit_q <= act_q && rbit;
					o_done_q <= !act_q && last_q;
					o_rng_q  <= near_rng_q;
					o_ang_q  <= near_ang_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_done_q;
	assign m_tdata  = {4'd0, o_ang_q, o_rng_q, o_rbit_q, o_col_q, o_row_q};

	// checks
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("word taken while another is in flight");

	a_read_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[10]) |-> (m_tuser == lbwg_pkg::KIND_NONE && !m_tlast))
		else $error("read result carries beam fields");

	a_xwall_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == lbwg_pkg::KIND_XWALL) |->
		(32'(m_tdata[4:0]) < GC + 1 && 32'(m_tdata[9:5]) < GC))
		else $error("x-wall cell outside store");

	a_near_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[27:11] <= lbwg_pkg::NO_RANGE))
		else $error("nearest range above limit");

endmodule

// ===== tb/lidar_beam_wall_grid_mapper_test.sv =====
// Testbench for the lidar wall mapper: random beams and cell reads checked against a predictor.
`timescale 1ns / 100ps

module lidar_beam_wall_grid_mapper_test;

	typedef struct packed {
		logic        action;
		logic [11:0] beam_index;
		logic [16:0] range_mm;
		logic        range_inf;
		logic        last_beam;
		logic        read_kind;
		logic [4:0]  read_row;
		logic [4:0]  read_col;
	} beam_word_t;

	typedef struct packed {
		logic [1:0]  wall_kind;
		logic [4:0]  cell_row;
		logic [4:0]  cell_col;
		logic        read_bit;
		logic        scan_done;
		logic [16:0] near_range;
		logic [15:0] near_angle;
	} map_word_t;

	localparam int FULL_ITEMS = 396;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int GC = lbwg_pkg::GRID_CELLS;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 1'b0, s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	lidar_beam_wall_grid_mapper uut (.*);

	always #2 clk = ~clk;

	// predictor state
	logic              x_walls [lbwg_pkg::STORE_DEPTH];
	logic              y_walls [lbwg_pkg::STORE_DEPTH];
	logic [16:0]       track_range;
	logic [15:0]       track_angle;
	logic              scan_active;
	logic signed [17:0] pose_x, pose_y;
	logic [15:0]       pose_heading, scan_first;
	logic [23:0]       beam_incr;

	beam_word_t pending_beams[$];
	map_word_t  expected_maps[$];
	int   failures = 0;
	bit   calm = 0;
	bit   in_fire = 0;
	int   send_gap = 0, recv_gap = 0;
	longint cycles = 0;

	function automatic map_word_t map_beam(beam_word_t w);
		map_word_t r;
		longint a, x, y, dx, dy, m, xi, yi, rr, cc;
		logic [23:0] sweep, a24;
		logic [47:0] prod;
		r = '0;
		if (w.action) begin
			rr = longint'(w.read_row); cc = longint'(w.read_col);
			if (!w.read_kind) begin
				if (rr < GC + 1 && cc < GC) r.read_bit = x_walls[rr*GC+cc];
			end else begin
				if (rr < GC && cc < GC + 1)
					r.read_bit = y_walls[rr*(GC+1)+cc];
			end
		end else begin
			prod = 48'(beam_incr) * 48'(w.beam_index);
			sweep = prod[23:0];
			if (!scan_active) begin
				track_range = lbwg_pkg::NO_RANGE; track_angle = '0; scan_active = 1;
			end
			if (!w.range_inf) begin
				a24 = sweep + {pose_heading, 8'd0};
				a = longint'($signed(a24));
				x = longint'(w.range_mm) * 39797; y = 0;
				if (a > (64'sd1 <<< 22)) begin y = x; x = 0; a -= 64'sd1 <<< 22; end
				else if (a < -(64'sd1 <<< 22)) begin y = -x; x = 0; a += 64'sd1 <<< 22; end
				for (int i = 0; i < lbwg_pkg::CORDIC_STEPS; i++) begin
					dx = y >>> i; dy = x >>> i;
					if (a >= 0) begin
						x -= dx; y += dy; a -= longint'(lbwg_pkg::atan_turn24(5'(i)));
					end else begin
						x += dx; y -= dy; a += longint'(lbwg_pkg::atan_turn24(5'(i)));
					end
				end
				x += longint'(pose_x) * 65536;
				y += longint'(pose_y) * 65536;
				if (x >= 0 && y >= 0) begin
					m = x % (500 * 65536);
					if (m > 350 * 65536 || m < 150 * 65536) begin
						xi = (x + 250 * 65536) / (500 * 65536);
						yi = (y + 250 * 65536) / (500 * 65536);
						if (xi % 2 == 0 && yi % 2 == 1) begin
							rr = xi / 2; cc = (yi - 1) / 2;
							if (rr < GC + 1 && cc < GC) begin
								x_walls[rr*GC+cc] = 1;
								r.wall_kind = lbwg_pkg::KIND_XWALL;
								r.cell_row = rr[4:0]; r.cell_col = cc[4:0];
							end else r.wall_kind = lbwg_pkg::KIND_OUT;
						end else if (xi % 2 == 1 && yi % 2 == 0) begin
							rr = (xi - 1) / 2; cc = yi / 2;
							if (rr < GC && cc < GC + 1) begin
								y_walls[rr*(GC+1)+cc] = 1;
								r.wall_kind = lbwg_pkg::KIND_YWALL;
								r.cell_row = rr[4:0]; r.cell_col = cc[4:0];
							end else r.wall_kind = lbwg_pkg::KIND_OUT;
						end
					end
				end
				if (w.range_mm < track_range) begin
					a24 = {scan_first, 8'd0} + sweep;
					track_range = w.range_mm;
					track_angle = 16'((25'(a24) + 25'd128) >> 8);
				end
			end
			if (w.last_beam) begin r.scan_done = 1; scan_active = 0; end
		end
		r.near_range = track_range;
		r.near_angle = track_angle;
		return r;
	endfunction

	task automatic queue_word(beam_word_t w);
		pending_beams.insert(pending_beams.size(), w);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			lbwg_pkg::REG_X:    pose_x = val[17:0];
			lbwg_pkg::REG_Y:    pose_y = val[17:0];
			lbwg_pkg::REG_HEAD: pose_heading = val[15:0];
			lbwg_pkg::REG_STEP: beam_incr = val[23:0];
			default:            scan_first = val[15:0];
		endcase
	endtask

	task automatic drain;
		while (pending_beams.size() != 0 || expected_maps.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic beam_word_t beam(int idx, int rng, bit inf, bit last);
		beam_word_t w;
		w = '0;
		w.beam_index = 12'(idx); w.range_mm = 17'(rng); w.range_inf = inf; w.last_beam = last;
		return w;
	endfunction

	function automatic beam_word_t cell_read(bit kind, int row, int col);
		beam_word_t w;
		w = '0;
		w.action = 1; w.read_kind = kind; w.read_row = 5'(row); w.read_col = 5'(col);
		return w;
	endfunction

	function automatic beam_word_t random_word;
		beam_word_t w;
		w = '0;
		if ($urandom_range(0, 3) == 0) begin
			w = cell_read(1'($urandom_range(0, 1)), int'($urandom_range(0, 17)),
				int'($urandom_range(0, 17)));
			if ($urandom_range(0, 9) == 0) begin
				w.read_row = 5'($urandom); w.read_col = 5'($urandom);
			end
			w.beam_index = 12'($urandom); w.range_mm = 17'($urandom);
		end else begin
			w = beam(int'($urandom_range(0, 4095)), $urandom_range(0, 10) == 0 ?
				int'($urandom_range(0, 99999)) : int'($urandom_range(100, 9000)),
				$urandom_range(0, 15) == 0, $urandom_range(0, 20) == 0);
			if ($urandom_range(0, 15) == 0) w.range_mm = 17'($urandom_range(100000, 131071));
			w.read_kind = 1'($urandom); w.read_row = 5'($urandom); w.read_col = 5'($urandom);
		end
		return w;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_fire) begin
				// hold word
			end else if (send_gap > 0) begin
				s_tvalid <= 0; send_gap <= send_gap - 1;
			end else if (pending_beams.size() != 0) begin
				beam_word_t w;
				w = pending_beams.pop_front();
				s_tvalid <= 1; s_tuser <= w.action; s_tlast <= w.last_beam;
				s_tdata <= {7'd0, w.read_col, w.read_row, w.read_kind, w.range_inf,
					w.range_mm, w.beam_index};
				if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 19);
			end else s_tvalid <= 0;
			if (recv_gap > 0) begin
				m_tready <= 0; recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1;
				if (!calm && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 19);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		in_fire <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			beam_word_t w;
			w.action = s_tuser; w.last_beam = s_tlast;
			{w.read_col, w.read_row, w.read_kind, w.range_inf, w.range_mm, w.beam_index} =
				s_tdata[40:0];
			expected_maps.insert(expected_maps.size(), map_beam(w));
		end
		if (m_tvalid && m_tready) begin
			map_word_t e;
			if (expected_maps.size() == 0) begin
				$error("result word with none expected");
				failures++;
			end else begin
				e = expected_maps.pop_front();
				if (m_tuser !== e.wall_kind) begin
					$error("wall_kind exp %0d got %0d", e.wall_kind, m_tuser); failures++; end
				if (m_tdata[4:0] !== e.cell_row) begin
					$error("cell_row exp %0d got %0d", e.cell_row, m_tdata[4:0]); failures++; end
				if (m_tdata[9:5] !== e.cell_col) begin
					$error("cell_col exp %0d got %0d", e.cell_col, m_tdata[9:5]); failures++; end
				if (m_tdata[10] !== e.read_bit) begin
					$error("read_bit exp %0d got %0d", e.read_bit, m_tdata[10]); failures++; end
				if (m_tlast !== e.scan_done) begin
					$error("scan_done exp %0d got %0d", e.scan_done, m_tlast); failures++; end
				if (m_tdata[27:11] !== e.near_range) begin
					$error("nearest_range_mm exp %0d got %0d", e.near_range, m_tdata[27:11]);
					failures++;
				end
				if (m_tdata[43:28] !== e.near_angle) begin
					$error("nearest_angle exp %0d got %0d", e.near_angle, m_tdata[43:28]);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < lbwg_pkg::STORE_DEPTH; i++) begin x_walls[i] = 0; y_walls[i] = 0; end
		track_range = lbwg_pkg::NO_RANGE; track_angle = '0; scan_active = 0;
		pose_x = '0; pose_y = '0; pose_heading = '0; beam_incr = '0; scan_first = '0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		// pose inside the grid, beams sweep whole turn
		reg_write(lbwg_pkg::REG_X, 32'd4000);
		reg_write(lbwg_pkg::REG_Y, 32'd4000);
		reg_write(lbwg_pkg::REG_HEAD, 32'd0);
		reg_write(lbwg_pkg::REG_STEP, 32'd4096);
		reg_write(lbwg_pkg::REG_FIRST, 32'h8000);
		// directed
		queue_word(beam(0, 0, 0, 0));
		queue_word(beam(4095, 99999, 0, 0));
		queue_word(beam(1024, 3000, 0, 0));
		queue_word(beam(2048, 3000, 0, 0));
		queue_word(beam(3072, 3000, 0, 0));
		queue_word(beam(512, 131071, 0, 0));
		queue_word(beam(100, 500, 1, 0));
		queue_word(beam(0, 4100, 0, 0));
		queue_word(beam(0, 4250, 0, 0));
		queue_word(beam(1024, 4500, 0, 0));
		queue_word(beam(2048, 9000, 0, 0));
		queue_word(beam(0, 20000, 0, 1));
		queue_word(beam(7, 1200, 0, 1));
		queue_word(cell_read(0, 16, 15));
		queue_word(cell_read(1, 15, 16));
		queue_word(cell_read(0, 31, 31));
		queue_word(cell_read(1, 16, 0));
		queue_word(cell_read(0, 0, 16));
		for (int r = 8; r < 10; r++) for (int c = 7; c < 10; c++)
			queue_word(cell_read(1'(c), r, c));
		drain;
		// extremes of the pose
		reg_write(lbwg_pkg::REG_X, 32'h1FFFF);
		reg_write(lbwg_pkg::REG_Y, 32'h20000);
		reg_write(lbwg_pkg::REG_HEAD, 32'h7FFF);
		reg_write(lbwg_pkg::REG_STEP, 32'hFFFFFF);
		reg_write(lbwg_pkg::REG_FIRST, 32'h7FFF);
		for (int i = 0; i < 15; i++) queue_word(random_word());
		drain;
		reg_write(lbwg_pkg::REG_X, 32'h20000);
		reg_write(lbwg_pkg::REG_Y, 32'h1FFFF);
		reg_write(lbwg_pkg::REG_HEAD, 32'h8000);
		reg_write(lbwg_pkg::REG_STEP, 32'd0);
		reg_write(lbwg_pkg::REG_FIRST, 32'h0);
		for (int i = 0; i < 15; i++) queue_word(random_word());
		drain;
		// random phases, pose inside the grid
		for (int ph = 0; ph < 6; ph++) begin
			reg_write(lbwg_pkg::REG_X, $urandom_range(500, 15500));
			reg_write(lbwg_pkg::REG_Y, $urandom_range(500, 15500));
			reg_write(lbwg_pkg::REG_HEAD, $urandom);
			reg_write(lbwg_pkg::REG_STEP,
				ph == 0 ? 32'hFFFFFF : $urandom_range(0, 32'hFFFFFF));
			reg_write(lbwg_pkg::REG_FIRST, $urandom);
			if (ph == 5) calm = 1;
			for (int i = 0; i < FULL_ITEMS / 6; i++) queue_word(random_word());
			drain;
		end
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lbwg_pkg.sv
rtl/lbwg_div.sv
rtl/lidar_beam_wall_grid_mapper.sv
tb/lidar_beam_wall_grid_mapper_test.sv
